@@ hdl/cbpn_pkg.sv @@
// ----------------------------------------------------------------------------
// cbpn_pkg
// Shared types and constants for the cubic Bezier point and normal sampler:
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package cbpn_pkg;

	localparam int CNT_W      = 6;
	// Eight point terms (four weights per coordinate), then six tangent terms.
	localparam int ACC_STEPS  = 14;
	localparam int ROOT_STEPS = 32;

	typedef struct packed {
		logic             load;
		logic             wgt1;
		logic             wgt2;
		logic             acc;
		logic             pinit;
		logic             pdiv;
		logic             norm;
		logic             sqa;
		logic             sqb;
		logic             root;
		logic             ninit;
		logic             ndiv;
		logic             emit;
		logic [CNT_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic degen;
		logic norm_done;
		logic out_free;
		logic last_sample;
	} stat_t;

endpackage

@@ hdl/cubic_bezier_points_and_normals.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_points_and_normals
// Samples a cubic Bezier segment into points with unit normals.
// ----------------------------------------------------------------------------
// One accepted transaction carries a segment of four control points; the block
// then emits num_intermediate + 2 samples (interior count clamped to
// MAX_INTERMEDIATE), index 0 to M, the final one flagged by last. Each sample
// is computed in turn by a shared multiply-accumulate, a restoring divider for
// the point, a one-bit-a-cycle tangent normaliser, a 32-step square root and a
// restoring divider for the normal. A zero tangent skips the normal and sets
// degenerate. A new segment is accepted only once the previous one has been
// fully emitted.
module cubic_bezier_points_and_normals #(
	parameter int COORD_WIDTH      = 24,
	parameter int NORMAL_FRAC_BITS = 14,
	parameter int MAX_INTERMEDIATE = 62
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [5:0]                    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] p0_x,
	input  logic signed [COORD_WIDTH-1:0] p0_y,
	input  logic signed [COORD_WIDTH-1:0] p1_x,
	input  logic signed [COORD_WIDTH-1:0] p1_y,
	input  logic signed [COORD_WIDTH-1:0] p2_x,
	input  logic signed [COORD_WIDTH-1:0] p2_y,
	input  logic signed [COORD_WIDTH-1:0] p3_x,
	input  logic signed [COORD_WIDTH-1:0] p3_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [5:0]                    sample_index,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y,
	output logic signed [15:0]            normal_x,
	output logic signed [15:0]            normal_y,
	output logic                          degenerate,
	output logic                          last
);
	import cbpn_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	cbpn_ctrl #(
		.COORD_WIDTH      (COORD_WIDTH),
		.NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cbpn_dp #(
		.COORD_WIDTH      (COORD_WIDTH),
		.NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
		.MAX_INTERMEDIATE (MAX_INTERMEDIATE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.p0_x         (p0_x),
		.p0_y         (p0_y),
		.p1_x         (p1_x),
		.p1_y         (p1_y),
		.p2_x         (p2_x),
		.p2_y         (p2_y),
		.p3_x         (p3_x),
		.p3_y         (p3_y),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_index (sample_index),
		.point_x      (point_x),
		.point_y      (point_y),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.degenerate   (degenerate),
		.last         (last)
	);

	// A segment in progress blocks the next one.
	a_one_segment: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a segment was still being expanded");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |-> (normal_x == 16'sd0 && normal_y == 16'sd0))
		else $error("degenerate sample carries a non-zero normal");

	// There is always at least one sample after the start point.
	a_last_not_first: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (sample_index != 6'd0))
		else $error("start sample flagged as last");

	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("sample written over an untaken result");

endmodule

@@ hdl/cbpn_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbpn_ctrl
// Sequencer for one segment: each sample gets weights, products, point division
// and, unless its tangent is zero, normalisation, square root and normal division.
// ----------------------------------------------------------------------------
module cbpn_ctrl #(
	parameter int COORD_WIDTH      = 24,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cbpn_pkg::stat_t stat,
	output cbpn_pkg::cmd_t  cmd
);
	import cbpn_pkg::*;

	localparam logic [CNT_W-1:0] ACC_LAST  = CNT_W'(ACC_STEPS - 1);
	localparam logic [CNT_W-1:0] PDIV_LAST = CNT_W'(COORD_WIDTH);
	localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);
	localparam logic [CNT_W-1:0] NDIV_LAST = CNT_W'(NORMAL_FRAC_BITS);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_WGT1  = 13'b0000000000010,
		S_WGT2  = 13'b0000000000100,
		S_ACC   = 13'b0000000001000,
		S_PINIT = 13'b0000000010000,
		S_PDIV  = 13'b0000000100000,
		S_NORM  = 13'b0000001000000,
		S_SQA   = 13'b0000010000000,
		S_SQB   = 13'b0000100000000,
		S_ROOT  = 13'b0001000000000,
		S_NINIT = 13'b0010000000000,
		S_NDIV  = 13'b0100000000000,
		S_EMIT  = 13'b1000000000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.step = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_WGT1;
				end
			end
			S_WGT1: begin
				cmd.wgt1 = 1'b1;
				state_d  = S_WGT2;
			end
			S_WGT2: begin
				cmd.wgt2 = 1'b1;
				cnt_d    = '0;
				state_d  = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (cnt_q == ACC_LAST) begin
					cnt_d   = '0;
					state_d = S_PINIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_PINIT: begin
				cmd.pinit = 1'b1;
				cnt_d     = '0;
				state_d   = S_PDIV;
			end
			S_PDIV: begin
				cmd.pdiv = 1'b1;
				if (cnt_q == PDIV_LAST) begin
					cnt_d   = '0;
					state_d = stat.degen ? S_EMIT : S_NORM;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_NORM: begin
				if (stat.norm_done) begin
					state_d = S_SQA;
				end else begin
					cmd.norm = 1'b1;
				end
			end
			S_SQA: begin
				cmd.sqa = 1'b1;
				state_d = S_SQB;
			end
			S_SQB: begin
				cmd.sqb = 1'b1;
				cnt_d   = '0;
				state_d = S_ROOT;
			end
			S_ROOT: begin
				cmd.root = 1'b1;
				if (cnt_q == ROOT_LAST) begin
					cnt_d   = '0;
					state_d = S_NINIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_NINIT: begin
				cmd.ninit = 1'b1;
				cnt_d     = '0;
				state_d   = S_NDIV;
			end
			S_NDIV: begin
				cmd.ndiv = 1'b1;
				if (cnt_q == NDIV_LAST) begin
					cnt_d   = '0;
					state_d = S_EMIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = stat.last_sample ? S_IDLE : S_WGT1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

@@ hdl/cbpn_dp.sv @@
// ----------------------------------------------------------------------------
// cbpn_dp
// Datapath: Bernstein weights, one shared multiply-accumulate, restoring
// dividers for the points and normals, tangent normaliser, bit-serial root.
// ----------------------------------------------------------------------------
module cbpn_dp #(
	parameter int COORD_WIDTH      = 24,
	parameter int NORMAL_FRAC_BITS = 14,
	parameter int MAX_INTERMEDIATE = 62
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [5:0]                    cfg_wdata,
	input  logic signed [COORD_WIDTH-1:0] p0_x,
	input  logic signed [COORD_WIDTH-1:0] p0_y,
	input  logic signed [COORD_WIDTH-1:0] p1_x,
	input  logic signed [COORD_WIDTH-1:0] p1_y,
	input  logic signed [COORD_WIDTH-1:0] p2_x,
	input  logic signed [COORD_WIDTH-1:0] p2_y,
	input  logic signed [COORD_WIDTH-1:0] p3_x,
	input  logic signed [COORD_WIDTH-1:0] p3_y,
	input  cbpn_pkg::cmd_t                cmd,
	output cbpn_pkg::stat_t               stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [5:0]                    sample_index,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y,
	output logic signed [15:0]            normal_x,
	output logic signed [15:0]            normal_y,
	output logic                          degenerate,
	output logic                          last
);
	import cbpn_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int F    = NORMAL_FRAC_BITS;
	localparam int WW   = 18;
	localparam int NUMW = CW + WW + 2;
	localparam int QP   = CW + 1;
	localparam int RP   = 21;
	localparam int DVW  = QP + RP;
	localparam int QN   = F + 1;
	localparam int RN   = 33;
	localparam int NNW  = QN + RN;

	logic [5:0]              nint_q;
	logic [6:0]              m_q;
	logic [5:0]              i_q;
	logic                    out_valid_q;
	logic signed [CW-1:0]    cp_q [4][2];
	logic [11:0]             uu_q, ui_q, ii_q;
	logic [12:0]             mm_q;
	logic [18:0]             m3_q;
	logic [WW-1:0]           w_q [4];
	logic [12:0]             t_q [4];
	logic signed [NUMW-1:0]  pacc_q [2];
	logic signed [NUMW-1:0]  dacc_q [2];
	logic [RP-1:0]           prem_q [2];
	logic [QP-1:0]           pq_q [2];
	logic                    pneg_q [2];
	logic [NUMW-1:0]         ax_q, ay_q;
	logic                    dxn_q, dyp_q, degen_q;
	logic [63:0]             s_q, r_q, bit_q;
	logic [RN-1:0]           nrem_q [2];
	logic [QN-1:0]           nq_q [2];

	logic [5:0]              u_w, nint_c;
	logic [1:0]              k_w;
	logic                    c_w;
	logic signed [CW:0]      mul_a;
	logic signed [WW:0]      mul_b;
	logic signed [NUMW-1:0]  prod;
	logic [NUMW-1:0]         mx;
	logic                    mx_hi;
	logic [30:0]             sq_op;
	logic [61:0]             sq_p;
	logic [63:0]             rb;
	logic [RP:0]             pdvs;
	logic [RN:0]             ndvs;
	logic signed [DVW-1:0]   pn [2];
	logic [DVW-1:0]          pabs [2];
	logic [NNW-1:0]          nnum [2];
	logic [RP:0]             ptr [2];
	logic [RN:0]             ntr [2];
	logic [QP-1:0]           pmag [2];
	logic [QP-1:0]           pval [2];
	logic signed [31:0]      nxs, nys;

	assign u_w    = 6'(m_q - 7'(i_q));
	assign nint_c = (nint_q > 6'(MAX_INTERMEDIATE)) ? 6'(MAX_INTERMEDIATE) : nint_q;

	// Step bit 3 selects tangent terms; bits 2:1 pick the term, bit 0 the axis.
	assign c_w = cmd.step[0];
	assign k_w = cmd.step[2:1];

	always_comb begin
		if (!cmd.step[3]) begin
			mul_a = (CW+1)'(cp_q[k_w][c_w]);
			mul_b = signed'({1'b0, w_q[k_w]});
		end else begin
			mul_a = (CW+1)'(cp_q[k_w + 2'd1][c_w]) - (CW+1)'(cp_q[k_w][c_w]);
			mul_b = signed'({1'b0, WW'(t_q[k_w])});
		end
	end
	assign prod = mul_a * mul_b;

	assign mx    = (ax_q > ay_q) ? ax_q : ay_q;
	assign mx_hi = |mx[NUMW-1:31];
	assign sq_op = cmd.sqa ? ax_q[30:0] : ay_q[30:0];
	assign sq_p  = 62'(sq_op) * 62'(sq_op);
	assign rb    = r_q + bit_q;
	assign pdvs  = (RP+1)'({m3_q, 1'b0});
	assign ndvs  = (RN+1)'(r_q[31:0]);

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			pn[c]   = (DVW'(pacc_q[c]) <<< 1) + DVW'(signed'({1'b0, m3_q}));
			pabs[c] = pn[c][DVW-1] ? DVW'(-pn[c]) : DVW'(pn[c]);
			ptr[c]  = {prem_q[c], pq_q[c][QP-1]};
			ntr[c]  = {nrem_q[c], nq_q[c][QN-1]};
			// Rounding was folded into the dividend; floor needs one more for
			// a negative dividend that leaves a remainder.
			pmag[c] = pq_q[c] + QP'(pneg_q[c] && (prem_q[c] != '0));
			pval[c] = pneg_q[c] ? QP'(-pmag[c]) : pmag[c];
		end
		nnum[0] = (NNW'(ay_q[30:0]) << F) + NNW'(r_q[31:1]);
		nnum[1] = (NNW'(ax_q[30:0]) << F) + NNW'(r_q[31:1]);
		nxs     = dyp_q ? -signed'(32'(nq_q[0])) : signed'(32'(nq_q[0]));
		nys     = dxn_q ? -signed'(32'(nq_q[1])) : signed'(32'(nq_q[1]));
	end

	assign stat.degen       = degen_q;
	assign stat.norm_done   = !mx_hi && mx[30];
	assign stat.out_free    = !out_valid_q || out_ready;
	assign stat.last_sample = (7'(i_q) == m_q);
	assign out_valid        = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nint_q      <= 6'd8;
			out_valid_q <= 1'b0;
			i_q         <= '0;
		end else begin
			if (cfg_we) begin
				nint_q <= cfg_wdata;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				i_q <= '0;
			end else if (cmd.emit) begin
				i_q <= i_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q        <= 7'(nint_c) + 7'd1;
			cp_q[0][0] <= p0_x;
			cp_q[0][1] <= p0_y;
			cp_q[1][0] <= p1_x;
			cp_q[1][1] <= p1_y;
			cp_q[2][0] <= p2_x;
			cp_q[2][1] <= p2_y;
			cp_q[3][0] <= p3_x;
			cp_q[3][1] <= p3_y;
		end
		if (cmd.wgt1) begin
			uu_q <= 12'(u_w) * 12'(u_w);
			ui_q <= 12'(u_w) * 12'(i_q);
			ii_q <= 12'(i_q) * 12'(i_q);
			mm_q <= 13'(m_q) * 13'(m_q);
		end
		if (cmd.wgt2) begin
			w_q[0]    <= WW'(uu_q) * WW'(u_w);
			w_q[1]    <= WW'(uu_q) * WW'(i_q) * WW'(3);
			w_q[2]    <= WW'(ii_q) * WW'(u_w) * WW'(3);
			w_q[3]    <= WW'(ii_q) * WW'(i_q);
			t_q[0]    <= 13'(uu_q);
			t_q[1]    <= 13'(ui_q) << 1;
			t_q[2]    <= 13'(ii_q);
			t_q[3]    <= '0;
			m3_q      <= 19'(mm_q) * 19'(m_q);
			pacc_q[0] <= '0;
			pacc_q[1] <= '0;
			dacc_q[0] <= '0;
			dacc_q[1] <= '0;
		end
		if (cmd.acc) begin
			if (!cmd.step[3]) begin
				pacc_q[c_w] <= pacc_q[c_w] + prod;
			end else begin
				dacc_q[c_w] <= dacc_q[c_w] + prod;
			end
		end
		if (cmd.pinit) begin
			for (int c = 0; c < 2; c++) begin
				prem_q[c] <= pabs[c][DVW-1:QP];
				pq_q[c]   <= pabs[c][QP-1:0];
				pneg_q[c] <= pn[c][DVW-1];
			end
			ax_q    <= dacc_q[0][NUMW-1] ? NUMW'(-dacc_q[0]) : NUMW'(dacc_q[0]);
			ay_q    <= dacc_q[1][NUMW-1] ? NUMW'(-dacc_q[1]) : NUMW'(dacc_q[1]);
			dxn_q   <= dacc_q[0][NUMW-1];
			dyp_q   <= !dacc_q[1][NUMW-1] && (dacc_q[1] != '0);
			degen_q <= (dacc_q[0] == '0) && (dacc_q[1] == '0);
		end
		if (cmd.pdiv) begin
			for (int c = 0; c < 2; c++) begin
				if (ptr[c] >= pdvs) begin
					prem_q[c] <= RP'(ptr[c] - pdvs);
					pq_q[c]   <= {pq_q[c][QP-2:0], 1'b1};
				end else begin
					prem_q[c] <= ptr[c][RP-1:0];
					pq_q[c]   <= {pq_q[c][QP-2:0], 1'b0};
				end
			end
		end
		if (cmd.norm) begin
			if (mx_hi) begin
				ax_q <= ax_q >> 1;
				ay_q <= ay_q >> 1;
			end else begin
				ax_q <= ax_q << 1;
				ay_q <= ay_q << 1;
			end
		end
		if (cmd.sqa) begin
			s_q   <= 64'(sq_p);
			r_q   <= '0;
			bit_q <= 64'(1) << 62;
		end
		if (cmd.sqb) begin
			s_q <= s_q + 64'(sq_p);
		end
		if (cmd.root) begin
			if (s_q >= rb) begin
				s_q <= s_q - rb;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.ninit) begin
			for (int c = 0; c < 2; c++) begin
				nrem_q[c] <= nnum[c][NNW-1:QN];
				nq_q[c]   <= nnum[c][QN-1:0];
			end
		end
		if (cmd.ndiv) begin
			for (int c = 0; c < 2; c++) begin
				if (ntr[c] >= ndvs) begin
					nrem_q[c] <= RN'(ntr[c] - ndvs);
					nq_q[c]   <= {nq_q[c][QN-2:0], 1'b1};
				end else begin
					nrem_q[c] <= ntr[c][RN-1:0];
					nq_q[c]   <= {nq_q[c][QN-2:0], 1'b0};
				end
			end
		end
		if (cmd.emit) begin
			sample_index <= i_q;
			point_x      <= pval[0][CW-1:0];
			point_y      <= pval[1][CW-1:0];
			normal_x     <= degen_q ? 16'sd0 : nxs[15:0];
			normal_y     <= degen_q ? 16'sd0 : nys[15:0];
			degenerate   <= degen_q;
			last         <= (7'(i_q) == m_q);
		end
	end

endmodule

@@ tb/cbpn_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cbpn_checker
// Watches the segment and sample channels of the Bezier sampler, works out
// every sample that an accepted segment must produce and compares each sample
// transaction field by field against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module cbpn_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [23:0] p0_x,
	input  logic [23:0] p0_y,
	input  logic [23:0] p1_x,
	input  logic [23:0] p1_y,
	input  logic [23:0] p2_x,
	input  logic [23:0] p2_y,
	input  logic [23:0] p3_x,
	input  logic [23:0] p3_y,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [5:0]  sample_index,
	input  logic [23:0] point_x,
	input  logic [23:0] point_y,
	input  logic [15:0] normal_x,
	input  logic [15:0] normal_y,
	input  logic        degenerate,
	input  logic        last,
	output int          errors,
	output int          pending
);

	localparam int MAX_INTERMEDIATE = 62;
	localparam int NORMAL_FRAC_BITS = 14;

	typedef struct packed {
		logic [5:0]  index;
		logic [23:0] px;
		logic [23:0] py;
		logic [15:0] nx;
		logic [15:0] ny;
		logic        degen;
		logic        last;
	} sample_t;

	sample_t     samples_due[$];
	logic [5:0]  interior_count;

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Bernstein-weighted point, rounded half upwards, and the unit normal of the
	// tangent at t = i/m.
	function automatic sample_t bezier_sample(longint q[8], longint m, longint i);
		sample_t         s;
		longint          u, m3, num, n2, d2;
		longint          w[4];
		longint          pt[2], dv[2];
		longint unsigned ax, ay, mx, r, mgx, mgy;
		u  = m - i;
		m3 = m * m * m;
		w[0] = u * u * u;
		w[1] = 3 * u * u * i;
		w[2] = 3 * u * i * i;
		w[3] = i * i * i;
		for (int c = 0; c < 2; c++) begin
			num = w[0] * q[c] + w[1] * q[2 + c] + w[2] * q[4 + c] + w[3] * q[6 + c];
			n2 = 2 * num + m3;
			d2 = 2 * m3;
			pt[c] = (n2 >= 0) ? n2 / d2 : -((-n2 + d2 - 1) / d2);
			dv[c] = u * u * (q[2 + c] - q[c]) + 2 * u * i * (q[4 + c] - q[2 + c])
				+ i * i * (q[6 + c] - q[4 + c]);
		end
		s.index = i[5:0];
		s.px    = pt[0][23:0];
		s.py    = pt[1][23:0];
		s.last  = (i == m);
		ax = (dv[0] < 0) ? -dv[0] : dv[0];
		ay = (dv[1] < 0) ? -dv[1] : dv[1];
		mx = (ax > ay) ? ax : ay;
		if (mx == 0) begin
			s.degen = 1'b1;
			s.nx    = '0;
			s.ny    = '0;
		end else begin
			// Scale both magnitudes so that the larger sits in [2^30, 2^31).
			while (mx >= (64'd1 << 31)) begin
				ax >>= 1; ay >>= 1; mx >>= 1;
			end
			while (mx < (64'd1 << 30)) begin
				ax <<= 1; ay <<= 1; mx <<= 1;
			end
			r   = int_sqrt(ax * ax + ay * ay);
			mgx = ((ay << NORMAL_FRAC_BITS) + (r >> 1)) / r;
			mgy = ((ax << NORMAL_FRAC_BITS) + (r >> 1)) / r;
			s.degen = 1'b0;
			s.nx    = (dv[1] > 0) ? -mgx[15:0] : mgx[15:0];
			s.ny    = (dv[0] < 0) ? -mgy[15:0] : mgy[15:0];
		end
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint  q[8];
		longint  m;
		sample_t want;
		if (!arst_n) begin
			interior_count = 6'd8;
			errors         = 0;
			samples_due.delete();
		end else begin
			if (in_valid && in_ready) begin
				q[0] = $signed(p0_x); q[1] = $signed(p0_y);
				q[2] = $signed(p1_x); q[3] = $signed(p1_y);
				q[4] = $signed(p2_x); q[5] = $signed(p2_y);
				q[6] = $signed(p3_x); q[7] = $signed(p3_y);
				m = ((interior_count > MAX_INTERMEDIATE) ? MAX_INTERMEDIATE
					: interior_count) + 1;
				for (longint i = 0; i <= m; i++)
					samples_due.push_back(bezier_sample(q, m, i));
			end
			if (cfg_we)
				interior_count = cfg_wdata;
			if (out_valid && out_ready) begin
				if (samples_due.size() == 0) begin
					$error("unexpected sample transaction, index %0d", sample_index);
					errors++;
				end else begin
					want = samples_due.pop_front();
					if (sample_index !== want.index) begin
						$error("sample_index: expected %0d, got %0d", want.index, sample_index);
						errors++;
					end
					if (point_x !== want.px) begin
						$error("point_x: expected %0d, got %0d", $signed(want.px),
							$signed(point_x));
						errors++;
					end
					if (point_y !== want.py) begin
						$error("point_y: expected %0d, got %0d", $signed(want.py),
							$signed(point_y));
						errors++;
					end
					if (normal_x !== want.nx) begin
						$error("normal_x: expected %0d, got %0d", $signed(want.nx),
							$signed(normal_x));
						errors++;
					end
					if (normal_y !== want.ny) begin
						$error("normal_y: expected %0d, got %0d", $signed(want.ny),
							$signed(normal_y));
						errors++;
					end
					if (degenerate !== want.degen) begin
						$error("degenerate: expected %0b, got %0b", want.degen, degenerate);
						errors++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						errors++;
					end
				end
			end
		end
		pending = samples_due.size();
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the cubic Bezier point and normal sampler.
// ----------------------------------------------------------------------------
// Drives directed segments (extreme coordinates, zero tangents, straight
// lines) and then random ones under several interior sample counts, including
// zero, the maximum and a value beyond it, with random idle bursts on both
// channels until a final stretch. The checker predicts and compares every sample.
module tb_top;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [5:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic signed [23:0] pt_drv [8];
	logic        out_valid;
	logic        out_ready;
	logic [5:0]  sample_index;
	logic signed [23:0] point_x, point_y;
	logic signed [15:0] normal_x, normal_y;
	logic        degenerate;
	logic        last;
	int          errors;
	int          pending;
	bit          quiet;
	int          segments_sent;

	localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
	localparam logic signed [23:0] CMIN = 24'sh800000;

	cubic_bezier_points_and_normals u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.p0_x(pt_drv[0]), .p0_y(pt_drv[1]), .p1_x(pt_drv[2]), .p1_y(pt_drv[3]),
		.p2_x(pt_drv[4]), .p2_y(pt_drv[5]), .p3_x(pt_drv[6]), .p3_y(pt_drv[7]),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample_index(sample_index), .point_x(point_x), .point_y(point_y),
		.normal_x(normal_x), .normal_y(normal_y),
		.degenerate(degenerate), .last(last)
	);

	cbpn_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.p0_x(pt_drv[0]), .p0_y(pt_drv[1]), .p1_x(pt_drv[2]), .p1_y(pt_drv[3]),
		.p2_x(pt_drv[4]), .p2_y(pt_drv[5]), .p3_x(pt_drv[6]), .p3_y(pt_drv[7]),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample_index(sample_index), .point_x(point_x), .point_y(point_y),
		.normal_x(normal_x), .normal_y(normal_y),
		.degenerate(degenerate), .last(last),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("DONE: errors detected");
		$finish;
	end

	// Sink side: random stall bursts until the final stretch of the run.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	// The block stays busy after an acceptance until its segment has been emitted,
	// so the wait before the next transaction costs nothing.
	task automatic send_segment(logic signed [23:0] pts [8]);
		bit acc;
		if (!quiet && $urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 17)) @(posedge clk);
		else
			@(posedge clk);
		for (int k = 0; k < 8; k++)
			pt_drv[k] <= pts[k];
		in_valid <= 1'b1;
		acc = 1'b0;
		while (!acc) begin
			@(negedge clk);
			acc = in_ready;
			@(posedge clk);
		end
		in_valid <= 1'b0;
		segments_sent++;
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (pending != 0);
		// Let the last sample's handshake and any internal tidy-up settle.
		repeat (300) @(posedge clk);
	endtask

	task automatic write_count(logic [5:0] n);
		wait_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic signed [23:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return CMAX;
			1: return CMIN;
			2: return $signed(24'($urandom_range(0, 2047))) - 24'sd1024;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_random(int count);
		logic signed [23:0] pts [8];
		logic signed [23:0] base;
		for (int n = 0; n < count; n++) begin
			for (int k = 0; k < 8; k++)
				pts[k] = 24'($urandom);
			case ($urandom_range(0, 9))
				0: begin
					for (int k = 0; k < 8; k++)
						pts[k] = rand_coord();
				end
				1: begin
					// Coincident control points give zero tangents at the ends.
					pts[2] = pts[0]; pts[3] = pts[1];
					pts[4] = pts[6]; pts[5] = pts[7];
				end
				2: begin
					// A small curve around one spot, so tangents are short.
					base = 24'($urandom);
					for (int k = 0; k < 8; k++)
						pts[k] = base + $signed(24'($urandom_range(0, 15))) - 24'sd8;
				end
				default: ;
			endcase
			send_segment(pts);
		end
	endtask

	initial begin
		logic signed [23:0] pts [8];
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		in_valid      = 1'b0;
		quiet         = 1'b0;
		segments_sent = 0;
		for (int k = 0; k < 8; k++)
			pt_drv[k] = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed segments under the reset interior count.
		pts = '{default: 24'sd0};
		send_segment(pts);
		pts = '{default: CMAX};
		send_segment(pts);
		pts = '{default: CMIN};
		send_segment(pts);
		pts = '{CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX};
		send_segment(pts);
		pts = '{CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX};
		send_segment(pts);
		pts = '{CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN};
		send_segment(pts);
		pts = '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd256, 24'sd256, 24'sd256, 24'sd256};
		send_segment(pts);
		pts = '{24'sd0, 24'sd0, 24'sd100, 24'sd0, 24'sd200, 24'sd0, 24'sd300, 24'sd0};
		send_segment(pts);
		pts = '{24'sd0, 24'sd0, 24'sd0, 24'sd300, 24'sd0, 24'sd600, 24'sd0, 24'sd900};
		send_segment(pts);
		pts = '{24'sd0, 24'sd0, 24'sd512, 24'sd512, 24'sd0, 24'sd512, 24'sd512, 24'sd0};
		send_segment(pts);
		pts = '{24'sd1, -24'sd1, 24'sd1, -24'sd1, 24'sd1, -24'sd1, 24'sd1, -24'sd1};
		send_segment(pts);
		pts = '{24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd0, 24'sd1, 24'sd1, 24'sd1};
		send_segment(pts);

		write_count(6'd0);
		pts = '{CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX};
		send_segment(pts);
		pts = '{default: 24'sd7};
		send_segment(pts);
		send_random(20);

		write_count(6'd63);
		send_random(2);
		write_count(6'd62);
		pts = '{CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN};
		send_segment(pts);
		send_random(1);

		write_count(6'd1);
		send_random(30);
		write_count(6'd3);
		send_random(30);
		write_count(6'($urandom_range(2, 10)));
		send_random(25);
		quiet = 1'b1;
		write_count(6'($urandom_range(0, 5)));
		send_random(25);

		wait_drained();
		$display("Sent %0d segments over interior counts 0, 1, 3, 8, 62, 63 and random,",
			segments_sent);
		$display("with idle bursts on both channels and a final stretch without them.");
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/cbpn_pkg.sv
hdl/cbpn_ctrl.sv
hdl/cbpn_dp.sv
hdl/cubic_bezier_points_and_normals.sv
tb/cbpn_checker.sv
tb/tb_top.sv
